### rtl/lsspf_pkg.sv
// Shared constants, field widths and result codes for the linear sieve
// smallest-prime-factor engine. No dependencies; used by the top level and its checker.
package lsspf_pkg;

  // Value and table geometry.
  localparam int VALUE_W   = 16;
  localparam int MAX_N     = 65535;
  localparam int PRIME_CAP = 8192;
  localparam int COUNT_W   = $clog2(PRIME_CAP + 1);
  localparam int PIDX_W    = $clog2(PRIME_CAP);
  localparam int PROD_W    = 2 * VALUE_W;

  // The first value the sieve visits, which is also the smallest prime.
  localparam logic [VALUE_W-1:0] FIRST_PRIME = VALUE_W'(2);

  // Limit register reset value.
  localparam logic [VALUE_W-1:0] LIMIT_RESET = VALUE_W'(MAX_N);

  // Operation selector carried in the input tuser.
  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result status codes.
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ABOVE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd2;

  // Result packing: factor, is_prime, prime_count, status, then zero fill.
  localparam int RESULT_W = VALUE_W + 1 + COUNT_W + STATUS_W;
  localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;
  localparam int PAD_W    = M_DATA_W - RESULT_W;

endpackage

### rtl/linear_sieve_spf_table.sv
// Linear sieve engine: keeps a smallest-prime-factor table and a prime list
// in two synchronous memories and answers factor queries from the table.
// Depends on lsspf_pkg.
//
// Usage:
//   cfg_valid/cfg_ready/cfg_data write the 16-bit limit register; cfg_ready
//   is always high. Write it only while the engine is idle.
//   The input stream carries one item per transfer: tuser selects build (0)
//   or query (1), tdata holds the queried value. Every item yields exactly
//   one result transfer on the output stream.
//   A query reads the table once into the read stage, which passes its result
//   on to the output register when that register is free; a new query can be
//   taken every cycle while the output side keeps up.
//   A build first clears table entries 0..limit, one per cycle, then walks
//   i = 2..limit: a read and a classify step for the table entry of i, and
//   for each prime tried against i a prime list read, then a multiply,
//   compare and table write. s_tready stays low for the whole build.
//   Reset clears the limit to 65535 and marks the table as not built;
//   queries then report the not-built status.
//   When the receiver stalls, the finished result waits in the output
//   register; one more query can be held in the read stage behind it before
//   s_tready drops.
module linear_sieve_spf_table (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lsspf_pkg::VALUE_W-1:0] cfg_data,
  // Input stream.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lsspf_pkg::VALUE_W-1:0] s_tdata,   // [15:0] value
  input  logic                          s_tuser,   // [0] operation
  // Output stream.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lsspf_pkg::M_DATA_W-1:0] m_tdata   // [15:0] factor, [16] is_prime,
                                                   // [30:17] prime_count,
                                                   // [32:31] status, rest zero
);

  localparam int VW = lsspf_pkg::VALUE_W;
  localparam int CW = lsspf_pkg::COUNT_W;
  localparam int PW = lsspf_pkg::PIDX_W;
  localparam int SW = lsspf_pkg::STATUS_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ_I,
    ST_CHECK_I,
    ST_PREAD,
    ST_PUSE,
    ST_DONE
  } state_t;

  // Control and sieve registers.
  state_t          state;
  logic [VW-1:0]   limit;
  logic [VW-1:0]   top;
  logic [VW-1:0]   clr;
  logic [VW-1:0]   i;
  logic [VW-1:0]   spf_i;
  logic [CW-1:0]   k;
  logic [CW-1:0]   primes_found;
  logic            built;
  logic [VW-1:0]   built_limit;

  // Query read stage.
  logic            q1_valid;
  logic [VW-1:0]   q1_value;
  logic [SW-1:0]   q1_status;

  // Output register.
  logic            out_valid;
  logic [VW-1:0]   out_factor;
  logic            out_prime;
  logic [CW-1:0]   out_count;
  logic [SW-1:0]   out_status;

  // Memory ports.
  logic [VW-1:0]   spf_mem [0:lsspf_pkg::MAX_N];
  logic [VW-1:0]   prime_mem [0:lsspf_pkg::PRIME_CAP-1];
  logic            spf_we, spf_re;
  logic [VW-1:0]   spf_waddr, spf_wdata, spf_raddr, spf_rdata;
  logic            pl_we, pl_re;
  logic [PW-1:0]   pl_waddr, pl_raddr;
  logic [VW-1:0]   pl_wdata, pl_rdata;

  // Handshake and sieve decisions.
  logic                        out_free;
  logic                        s_accept, query_acc, build_acc;
  logic                        build_fire;
  logic                        is_new, list_room, has_prime, prod_over, i_last;
  logic [lsspf_pkg::PROD_W-1:0] prod;
  logic [VW-1:0]               q_factor;
  logic                        q_prime;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE) && (!q1_valid || out_free);
  assign s_accept  = s_tvalid && s_tready;
  assign query_acc = s_accept && (s_tuser == lsspf_pkg::OP_QUERY);
  assign build_acc = s_accept && (s_tuser == lsspf_pkg::OP_BUILD);

  // The build result leaves once earlier results are out of the way.
  assign build_fire = (state == ST_DONE) && !q1_valid && out_free;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{lsspf_pkg::PAD_W{1'b0}}, out_status, out_count, out_prime, out_factor};

  // Sieve decisions on the registered memory outputs.
  assign is_new    = (spf_rdata == '0);
  assign list_room = (primes_found < CW'(lsspf_pkg::PRIME_CAP));
  assign has_prime = (k < primes_found);
  assign prod      = lsspf_pkg::PROD_W'(i) * lsspf_pkg::PROD_W'(pl_rdata);
  assign prod_over = (prod > lsspf_pkg::PROD_W'(top));
  assign i_last    = (i == top);

  // Query result from the table read.
  assign q_factor = (q1_status == lsspf_pkg::STATUS_OK) ? spf_rdata : '0;
  assign q_prime  = (q1_status == lsspf_pkg::STATUS_OK) && (q1_value >= lsspf_pkg::FIRST_PRIME)
                    && (spf_rdata == q1_value);

  // Memory port control per state.
  always_comb begin
    spf_we    = 1'b0;
    spf_waddr = i;
    spf_wdata = i;
    spf_re    = 1'b0;
    spf_raddr = i;
    pl_we     = 1'b0;
    pl_waddr  = primes_found[PW-1:0];
    pl_wdata  = i;
    pl_re     = 1'b0;
    pl_raddr  = k[PW-1:0];
    unique case (state)
      ST_IDLE: begin
        spf_re    = query_acc;
        spf_raddr = s_tdata;
      end
      ST_CLEAR: begin
        spf_we    = 1'b1;
        spf_waddr = clr;
        spf_wdata = '0;
      end
      ST_READ_I: begin
        spf_re = 1'b1;
      end
      ST_CHECK_I: begin
        spf_we = is_new;
        pl_we  = is_new && list_room;
      end
      ST_PREAD: begin
        pl_re = has_prime;
      end
      ST_PUSE: begin
        spf_we    = !prod_over;
        spf_waddr = prod[VW-1:0];
        spf_wdata = pl_rdata;
      end
      ST_DONE: begin
        spf_we = 1'b0;
      end
      default: begin
        spf_we = 1'b0;
      end
    endcase
  end

  // Smallest-prime-factor table: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (spf_we) begin
      spf_mem[spf_waddr] <= spf_wdata;
    end
    if (spf_re) begin
      spf_rdata <= spf_mem[spf_raddr];
    end
  end

  // Prime list: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (pl_we) begin
      prime_mem[pl_waddr] <= pl_wdata;
    end
    if (pl_re) begin
      pl_rdata <= prime_mem[pl_raddr];
    end
  end

  // Sequencer, query stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      limit        <= lsspf_pkg::LIMIT_RESET;
      primes_found <= '0;
      built        <= 1'b0;
      built_limit  <= '0;
      q1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end

      // A new query captures its status while the table read is in flight;
      // otherwise the read stage empties into the output register.
      if (query_acc) begin
        q1_valid <= 1'b1;
        q1_value <= s_tdata;
        if (!built) begin
          q1_status <= lsspf_pkg::STATUS_NOT_BUILT;
        end else if (s_tdata > built_limit) begin
          q1_status <= lsspf_pkg::STATUS_ABOVE;
        end else begin
          q1_status <= lsspf_pkg::STATUS_OK;
        end
      end else if (q1_valid && out_free) begin
        q1_valid <= 1'b0;
      end

      // Output register: filled by the query stage or the build result,
      // emptied by an output transfer with nothing to refill it.
      if (q1_valid && out_free) begin
        out_valid  <= 1'b1;
        out_factor <= q_factor;
        out_prime  <= q_prime;
        out_count  <= primes_found;
        out_status <= q1_status;
      end else if (build_fire) begin
        out_valid  <= 1'b1;
        out_factor <= '0;
        out_prime  <= 1'b0;
        out_count  <= primes_found;
        out_status <= lsspf_pkg::STATUS_OK;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (build_acc) begin
            top          <= limit;
            clr          <= '0;
            primes_found <= '0;
            state        <= ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          if (clr == top) begin
            i     <= lsspf_pkg::FIRST_PRIME;
            state <= (top < lsspf_pkg::FIRST_PRIME) ? ST_DONE : ST_READ_I;
          end else begin
            clr <= clr + VW'(1);
          end
        end
        ST_READ_I: begin
          state <= ST_CHECK_I;
        end
        ST_CHECK_I: begin
          // An entry still zero here was never marked, so i is prime.
          if (is_new) begin
            spf_i <= i;
            if (list_room) begin
              primes_found <= primes_found + CW'(1);
            end
          end else begin
            spf_i <= spf_rdata;
          end
          k     <= '0;
          state <= ST_PREAD;
        end
        ST_PREAD: begin
          if (has_prime) begin
            state <= ST_PUSE;
          end else if (i_last) begin
            state <= ST_DONE;
          end else begin
            i     <= i + VW'(1);
            state <= ST_READ_I;
          end
        end
        ST_PUSE: begin
          // Stop past the limit or after the smallest prime of i was used.
          if (prod_over || (pl_rdata == spf_i)) begin
            if (i_last) begin
              state <= ST_DONE;
            end else begin
              i     <= i + VW'(1);
              state <= ST_READ_I;
            end
          end else begin
            k     <= k + CW'(1);
            state <= ST_PREAD;
          end
        end
        ST_DONE: begin
          // The table becomes valid once the build result is loaded.
          if (build_fire) begin
            built       <= 1'b1;
            built_limit <= top;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/lsspf_checker.sv
// Port-level checker for the linear sieve engine, bound to its top level.
// Depends on lsspf_pkg and linear_sieve_spf_table.
module lsspf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic [lsspf_pkg::M_DATA_W-1:0] m_tdata
);

  localparam int VW = lsspf_pkg::VALUE_W;
  localparam int CW = lsspf_pkg::COUNT_W;
  localparam int SW = lsspf_pkg::STATUS_W;

  logic [VW-1:0] factor;
  logic          is_prime;
  logic [CW-1:0] prime_count;
  logic [SW-1:0] status;

  assign factor      = m_tdata[VW-1:0];
  assign is_prime    = m_tdata[VW];
  assign prime_count = m_tdata[VW+CW:VW+1];
  assign status      = m_tdata[VW+CW+SW:VW+CW+1];

  // No result may be offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // An error result carries no factor and no primality flag.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status != lsspf_pkg::STATUS_OK) |-> (factor == '0 && !is_prime))
    else $error("error result with nonzero factor or prime flag");

  // A prime answer is an ok query whose factor is at least two.
  a_prime_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && is_prime) |->
      (status == lsspf_pkg::STATUS_OK && factor >= lsspf_pkg::FIRST_PRIME))
    else $error("prime flag on a bad result");

  // The prime count never passes the prime list capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (prime_count <= CW'(lsspf_pkg::PRIME_CAP)))
    else $error("prime count above capacity");

endmodule

bind linear_sieve_spf_table lsspf_checker u_lsspf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tdata  (m_tdata)
);
